>>> sv/triangle_tangent_generator_defines.svh
// Assertion macros shared by the checker of the tangent generator.
// Depends on nothing; the including module supplies clk and rst.
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tangent generator check failed");

// Next-cycle implication, sampled on clk, off during reset
`define TTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tangent generator check failed");

`endif

>>> sv/ttg_pkg.sv
// Types, command codes and constants of the triangle tangent generator.
// Used by the controller, the datapath, the top level and the checker.
package ttg_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
    logic               last_copy;
  } out_item_t;

  // Datapath operations
  localparam logic [3:0] OP_IDLE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_DIFF    = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_ABS     = 4'd4;
  localparam logic [3:0] OP_NORM    = 4'd5;
  localparam logic [3:0] OP_SQ      = 4'd6;
  localparam logic [3:0] OP_SQRT    = 4'd7;
  localparam logic [3:0] OP_DIV     = 4'd8;
  localparam logic [3:0] OP_DIV_END = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] cnt;
    logic [1:0] comp;
    logic       vsel;
    logic       slot;
    logic       degen;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic norm_done;
  } status_t;

  localparam logic [5:0]  MUL_LAST  = 6'd14;
  localparam logic [5:0]  SQ_LAST   = 6'd3;
  localparam logic [5:0]  SQRT_LAST = 6'd31;
  localparam logic [5:0]  DIV_LAST  = 6'd31;
  localparam logic [1:0]  COMP_LAST = 2'd2;
  localparam logic [1:0]  COPY_LAST = 2'd2;
  localparam logic [1:0]  PHASE_TRI = 2'd2;
  localparam logic [30:0] FLUSH_LIMIT = 31'd1074;

endpackage

>>> sv/ttg_ctrl.sv
// Sequencer of the tangent generator: vertex phase, step counters, emission.
// Depends on ttg_pkg; drives ttg_datapath through a command struct.
module ttg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             vertex_valid,
  output logic             vertex_ready,
  output logic             tangent_valid,
  input  logic             tangent_ready,
  input  ttg_pkg::status_t status,
  output ttg_pkg::cmd_t    cmd
);
  import ttg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;
  logic [1:0] phase;
  logic [5:0] cnt;
  logic [1:0] comp;
  logic       vsel;
  logic       degen;
  logic [1:0] copy;
  logic       acc;

  // Accept vertices when idle, and the first two of a triangle while emitting
  assign vertex_ready  = (state == S_IDLE) || ((state == S_EMIT) && (phase != PHASE_TRI));
  assign acc           = vertex_valid && vertex_ready;
  assign tangent_valid = (state == S_EMIT);

  // Decode the datapath command
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_IDLE;
    cmd.cnt   = cnt;
    cmd.comp  = comp;
    cmd.vsel  = vsel;
    cmd.slot  = phase[0];
    cmd.degen = degen;
    cmd.last  = (copy == COPY_LAST);
    unique case (state)
      S_IDLE, S_EMIT: begin
        if (acc) cmd.op = (phase == PHASE_TRI) ? OP_DIFF : OP_LOAD;
      end
      S_MUL:  cmd.op = OP_MUL;
      S_ABS:  cmd.op = OP_ABS;
      S_NORM: begin
        if (!status.vec_zero && !status.norm_done) cmd.op = OP_NORM;
      end
      S_SQ:   cmd.op = OP_SQ;
      S_SQRT: cmd.op = OP_SQRT;
      S_DIV:  cmd.op = (cnt == DIV_LAST) ? OP_DIV_END : OP_DIV;
      default: cmd.op = OP_IDLE;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
      cnt   <= '0;
      comp  <= '0;
      vsel  <= 1'b0;
      degen <= 1'b0;
      copy  <= '0;
    end else begin
      unique case (state)
        S_IDLE, S_EMIT: begin
          if (acc) begin
            if (phase == PHASE_TRI) begin
              phase <= '0;
              cnt   <= '0;
              degen <= 1'b0;
              state <= S_MUL;
            end else begin
              phase <= phase + 2'd1;
            end
          end
          if ((state == S_EMIT) && tangent_ready) begin
            if (copy == COPY_LAST) begin
              copy  <= '0;
              state <= S_IDLE;
            end else begin
              copy <= copy + 2'd1;
            end
          end
        end
        S_MUL: begin
          if (cnt == MUL_LAST) begin
            cnt  <= '0;
            vsel <= 1'b0;
            if (status.det_zero) begin
              degen <= 1'b1;
              state <= S_EMIT;
            end else begin
              state <= S_ABS;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ABS: state <= S_NORM;
        S_NORM: begin
          if (status.vec_zero) begin
            degen <= 1'b1;
            state <= S_EMIT;
          end else if (status.norm_done) begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt == SQ_LAST) begin
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SQRT: begin
          if (cnt == SQRT_LAST) begin
            cnt   <= '0;
            comp  <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          if (cnt == DIV_LAST) begin
            cnt <= '0;
            if (comp == COMP_LAST) begin
              comp <= '0;
              if (vsel) begin
                state <= S_EMIT;
              end else begin
                vsel  <= 1'b1;
                state <= S_ABS;
              end
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ttg_datapath.sv
// Datapath of the tangent generator: held vertices, differences, shared
// multiplier, normalising shifter, square root and divider. Uses ttg_pkg.
module ttg_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  ttg_pkg::in_item_t   vertex,
  input  ttg_pkg::cmd_t       cmd,
  output ttg_pkg::status_t    status,
  output ttg_pkg::out_item_t  tangent
);
  import ttg_pkg::*;

  localparam int EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int DW  = EFF + 1;
  localparam int MW  = (DW > 32) ? DW : 32;
  localparam int PW  = 2 * MW;
  localparam int XW  = 2 * DW + 1;

  logic [4:0][31:0]              vin;
  logic [1:0][4:0][EFF-1:0]      hv;
  logic signed [DW-1:0]          dv0 [3];
  logic signed [DW-1:0]          dv1 [3];
  logic signed [DW-1:0]          t0u, t0v, t1u, t1v;
  logic signed [MW-1:0]          opa, opb;
  logic signed [PW-1:0]          prod;
  logic signed [XW-1:0]          acc;
  logic signed [XW-1:0]          cr [7];
  logic [XW-1:0]                 m [3];
  logic [XW-1:0]                 m_or;
  logic [2:0]                    neg;
  logic [63:0]                   s;
  logic [63:0]                   sr, sres;
  logic [63:0]                   sq_bit, sr_src, sres_src, sq_t;
  logic [6:0]                    sq_sh;
  logic [32:0]                   n;
  logic [33:0]                   dr, rin;
  logic                          ge;
  logic [30:0]                   q, qf;
  logic [31:0]                   qval;
  logic [31:0]                   ov [2][3];
  logic [1:0]                    msel;
  logic [2:0]                    kj;
  logic [1:0]                    ki;
  logic                          flip;

  assign vin = {vertex.tex_v, vertex.tex_u, vertex.pos_z, vertex.pos_y, vertex.pos_x};

  // Hold the first two vertices of a triangle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      for (int f = 0; f < 5; f++) hv[cmd.slot][f] <= vin[f][EFF-1:0];
    end
  end

  // Form edge differences when the third vertex arrives
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        dv0[i] <= $signed({hv[1][i][EFF-1], hv[1][i]}) - $signed({hv[0][i][EFF-1], hv[0][i]});
        dv1[i] <= $signed({vin[i][EFF-1], vin[i][EFF-1:0]})
                  - $signed({hv[0][i][EFF-1], hv[0][i]});
      end
      t0u <= $signed({hv[1][3][EFF-1], hv[1][3]}) - $signed({hv[0][3][EFF-1], hv[0][3]});
      t0v <= $signed({hv[1][4][EFF-1], hv[1][4]}) - $signed({hv[0][4][EFF-1], hv[0][4]});
      t1u <= $signed({vin[3][EFF-1], vin[3][EFF-1:0]})
             - $signed({hv[0][3][EFF-1], hv[0][3]});
      t1v <= $signed({vin[4][EFF-1], vin[4][EFF-1:0]})
             - $signed({hv[0][4][EFF-1], hv[0][4]});
    end
  end

  // Select operands of the shared multiplier
  assign kj   = cmd.cnt[3:1];
  assign msel = (cmd.op == OP_SQ) ? cmd.cnt[1:0] : cmd.comp;
  always_comb begin
    ki  = 2'd0;
    opa = '0;
    opb = '0;
    if (cmd.op == OP_SQ) begin
      opa = $signed(MW'({1'b0, m[msel][30:0]}));
      opb = opa;
    end else begin
      unique case (kj)
        3'd0: begin
          opa = MW'(cmd.cnt[0] ? t0v : t0u);
          opb = MW'(cmd.cnt[0] ? t1u : t1v);
        end
        3'd1, 3'd2, 3'd3: begin
          ki  = 2'(kj - 3'd1);
          opa = MW'(cmd.cnt[0] ? dv1[ki] : dv0[ki]);
          opb = MW'(cmd.cnt[0] ? t0v : t1v);
        end
        3'd4, 3'd5, 3'd6: begin
          ki  = 2'(kj - 3'd4);
          opa = MW'(cmd.cnt[0] ? dv0[ki] : dv1[ki]);
          opb = MW'(cmd.cnt[0] ? t1u : t0u);
        end
        default: begin
          opa = '0;
          opb = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // Accumulate cross products: det, tangent and bitangent directions
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_MUL) && (cmd.cnt != 6'd0)) begin
      if (cmd.cnt[0]) acc <= XW'(prod);
      else cr[3'(cmd.cnt[3:1] - 3'd1)] <= acc - XW'(prod);
    end
  end

  assign flip = ~cr[0][XW-1];

  // Take magnitudes, then shift all three until the largest fills bit 30
  always_comb begin
    m_or = '0;
    for (int i = 0; i < 3; i++) m_or = m_or | m[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ABS) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= cr[cmd.vsel ? 4 + i : 1 + i][XW-1];
        m[i]   <= cr[cmd.vsel ? 4 + i : 1 + i][XW-1]
                  ? XW'(-cr[cmd.vsel ? 4 + i : 1 + i])
                  : XW'(cr[cmd.vsel ? 4 + i : 1 + i]);
      end
    end else if (cmd.op == OP_NORM) begin
      for (int i = 0; i < 3; i++) begin
        if (m_or[XW-1:31] != '0) m[i] <= m[i] >> 1;
        else m[i] <= m[i] << 1;
      end
    end
  end

  // Sum of squares, one product a cycle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ) begin
      if (cmd.cnt == 6'd1) s <= 64'(prod[61:0]);
      else if (cmd.cnt != 6'd0) s <= s + 64'(prod[61:0]);
    end
  end

  // Integer square root, one result bit a cycle
  assign sq_sh    = 7'd62 - {cmd.cnt, 1'b0};
  assign sq_bit   = 64'd1 << sq_sh;
  assign sr_src   = (cmd.cnt == 6'd0) ? s : sr;
  assign sres_src = (cmd.cnt == 6'd0) ? 64'd0 : sres;
  assign sq_t     = sres_src + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT) begin
      if (sr_src >= sq_t) begin
        sr   <= sr_src - sq_t;
        sres <= (sres_src >> 1) + sq_bit;
      end else begin
        sr   <= sr_src;
        sres <= sres_src >> 1;
      end
    end
  end
  assign n = sres[32:0];

  // Restoring division of a*2^30 by n; the quotient never exceeds 2^30
  assign rin = (cmd.cnt == 6'd0) ? 34'(m[msel][30:0]) : {dr[32:0], 1'b0};
  assign ge  = (rin >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV) begin
      dr <= ge ? (rin - {1'b0, n}) : rin;
      q  <= {q[29:0], ge};
    end
  end

  // Flush tiny components, apply the sign and store
  assign qf   = (q < FLUSH_LIMIT) ? 31'd0 : q;
  assign qval = (neg[msel] ^ flip) ? (32'd0 - {1'b0, qf}) : {1'b0, qf};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_END) ov[cmd.vsel][msel] <= qval;
  end

  assign status.det_zero  = (cr[0] == '0);
  assign status.vec_zero  = (m_or == '0);
  assign status.norm_done = (m_or[XW-1:31] == '0) && m_or[30];

  // Present the result, zeroed when degenerate
  always_comb begin
    tangent.tangent_x   = cmd.degen ? 32'sd0 : $signed(ov[0][0]);
    tangent.tangent_y   = cmd.degen ? 32'sd0 : $signed(ov[0][1]);
    tangent.tangent_z   = cmd.degen ? 32'sd0 : $signed(ov[0][2]);
    tangent.bitangent_x = cmd.degen ? 32'sd0 : $signed(ov[1][0]);
    tangent.bitangent_y = cmd.degen ? 32'sd0 : $signed(ov[1][1]);
    tangent.bitangent_z = cmd.degen ? 32'sd0 : $signed(ov[1][2]);
    tangent.degenerate  = cmd.degen;
    tangent.last_copy   = cmd.last;
  end

endmodule

>>> sv/triangle_tangent_generator.sv
// Channel   | signals                                 | payload
// vertex    | vertex_valid, vertex_ready, vertex      | in_item_t (Q16.16)
// tangent   | tangent_valid, tangent_ready, tangent   | out_item_t (Q2.30)
//
// The first two vertices of a triangle are held on arrival. The third starts
// the multiply steps, then per vector a magnitude step, normalising, square,
// root and divide steps (shared multiplier, one-bit-a-cycle root and divider),
// shortened when degenerate, then three tangent transactions.
// Reset (rst, synchronous) clears the vertex phase; stalls on tangent hold the
// result while the next triangle's first two vertices may still enter.
// Top level; depends on ttg_pkg, ttg_ctrl and ttg_datapath.
module triangle_tangent_generator #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vertex_valid,
  output logic                vertex_ready,
  input  ttg_pkg::in_item_t   vertex,
  output logic                tangent_valid,
  input  logic                tangent_ready,
  output ttg_pkg::out_item_t  tangent
);
  import ttg_pkg::*;

  cmd_t    cmd;
  status_t status;

  ttg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .vertex_valid  (vertex_valid),
    .vertex_ready  (vertex_ready),
    .tangent_valid (tangent_valid),
    .tangent_ready (tangent_ready),
    .status        (status),
    .cmd           (cmd)
  );

  ttg_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk     (clk),
    .vertex  (vertex),
    .cmd     (cmd),
    .status  (status),
    .tangent (tangent)
  );

endmodule

>>> sv/ttg_checker.sv
// Port-level checks of the tangent generator, bound to the top level.
// Depends on ttg_pkg and triangle_tangent_generator_defines.svh.
`include "triangle_tangent_generator_defines.svh"

module ttg_checker (
  input logic               clk,
  input logic               rst,
  input logic               tangent_valid,
  input logic               tangent_ready,
  input ttg_pkg::out_item_t tangent
);
  import ttg_pkg::*;

  // Hold the result until taken
  `TTG_ASSERT_NEXT(a_hold, tangent_valid && !tangent_ready, tangent_valid && $stable(tangent))

  // Degenerate results carry zero vectors
  `TTG_ASSERT_NOW(a_degen_zero, tangent_valid && tangent.degenerate, (tangent.tangent_x == 0) && (tangent.tangent_y == 0) && (tangent.tangent_z == 0) && (tangent.bitangent_x == 0) && (tangent.bitangent_y == 0) && (tangent.bitangent_z == 0))

  // Nothing follows the last copy of a triangle at once
  `TTG_ASSERT_NEXT(a_last_ends, tangent_valid && tangent_ready && tangent.last_copy, !tangent_valid)

  // The x components stay within one in Q2.30
  `TTG_ASSERT_NOW(a_unit_range, tangent_valid, (tangent.tangent_x <= 32'sd1073741824) && (tangent.tangent_x >= -32'sd1073741824) && (tangent.bitangent_x <= 32'sd1073741824) && (tangent.bitangent_x >= -32'sd1073741824))

endmodule

bind triangle_tangent_generator ttg_checker u_ttg_checker (.*);

>>> bench/ttg_checker.sv
// Checker for the triangle tangent generator: watches both channels, predicts
// the tangent frames of each triangle and compares them. Depends on ttg_pkg.
`timescale 1ns / 1ps
module ttg_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               vertex_valid,
  input  logic               vertex_ready,
  input  ttg_pkg::in_item_t  vertex,
  input  logic               tangent_valid,
  input  logic               tangent_ready,
  input  ttg_pkg::out_item_t tangent,
  output int                 error_count,
  output int                 frames_waiting
);
  import ttg_pkg::*;

  typedef logic signed [127:0] wide_t;

  out_item_t  frame_queue[$];
  in_item_t   corner_a, corner_b;
  logic [1:0] corner_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [63:0] int_root(input logic [63:0] s);
    logic [63:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic int bit_length(input logic [127:0] m);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (m[i]) n = i + 1;
    return n;
  endfunction

  // Normalise one direction to Q2.30; ok drops when the direction is empty
  function automatic void unit_dir(input wide_t dx, input wide_t dy, input wide_t dz,
                                   input bit flip, output logic [31:0] o[3],
                                   output bit ok);
    wide_t       d[3];
    logic [127:0] mag[3], m;
    bit          neg[3];
    int          top;
    logic [63:0] a[3], s, n, q;
    d[0] = dx; d[1] = dy; d[2] = dz;
    top = 0;
    s = '0;
    ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o[i] = '0;
      neg[i] = d[i] < 0;
      mag[i] = neg[i] ? -d[i] : d[i];
      if (bit_length(mag[i]) > top) top = bit_length(mag[i]);
    end
    if (top == 0) return;
    for (int i = 0; i < 3; i++) begin
      m = top > 31 ? mag[i] >> (top - 31) : mag[i] << (31 - top);
      a[i] = m[63:0];
      s += a[i] * a[i];
    end
    n = int_root(s);
    if (n == 0) return;
    for (int i = 0; i < 3; i++) begin
      q = (a[i] << 30) / n;
      if (q > 64'd1 << 30) q = 64'd1 << 30;
      if (q < FLUSH_LIMIT) q = '0;
      o[i] = (neg[i] != flip) ? -q[31:0] : q[31:0];
    end
    ok = 1'b1;
  endfunction

  // Work out the frame of a completed triangle and queue its three copies
  function automatic void predict_frame(input in_item_t va, input in_item_t vb,
                                        input in_item_t vc);
    wide_t      dv0[3], dv1[3], t0u, t0v, t1u, t1v, det, tdir[3], bdir[3];
    logic [31:0] tv[3], bv[3];
    bit         ok_t, ok_b, degen;
    out_item_t  f;
    dv0[0] = wide_t'(vb.pos_x) - wide_t'(va.pos_x);
    dv0[1] = wide_t'(vb.pos_y) - wide_t'(va.pos_y);
    dv0[2] = wide_t'(vb.pos_z) - wide_t'(va.pos_z);
    dv1[0] = wide_t'(vc.pos_x) - wide_t'(va.pos_x);
    dv1[1] = wide_t'(vc.pos_y) - wide_t'(va.pos_y);
    dv1[2] = wide_t'(vc.pos_z) - wide_t'(va.pos_z);
    t0u = wide_t'(vb.tex_u) - wide_t'(va.tex_u);
    t0v = wide_t'(vb.tex_v) - wide_t'(va.tex_v);
    t1u = wide_t'(vc.tex_u) - wide_t'(va.tex_u);
    t1v = wide_t'(vc.tex_v) - wide_t'(va.tex_v);
    det = t0u * t1v - t0v * t1u;
    for (int i = 0; i < 3; i++) begin
      tdir[i] = dv0[i] * t1v - dv1[i] * t0v;
      bdir[i] = dv1[i] * t0u - dv0[i] * t1u;
    end
    degen = det == 0;
    ok_t = 1'b0;
    ok_b = 1'b0;
    if (!degen) begin
      unit_dir(tdir[0], tdir[1], tdir[2], det > 0, tv, ok_t);
      unit_dir(bdir[0], bdir[1], bdir[2], det > 0, bv, ok_b);
      degen = !ok_t || !ok_b;
    end
    f = '0;
    if (!degen) begin
      f.tangent_x   = tv[0];
      f.tangent_y   = tv[1];
      f.tangent_z   = tv[2];
      f.bitangent_x = bv[0];
      f.bitangent_y = bv[1];
      f.bitangent_z = bv[2];
    end
    f.degenerate = degen;
    for (int k = 0; k < 3; k++) begin
      f.last_copy = k == 2;
      frame_queue = {frame_queue, f};
    end
  endfunction

  // Track vertices and compare each tangent transaction with the oldest frame
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      corner_count <= '0;
      error_count  = 0;
    end else begin
      if (vertex_valid && vertex_ready) begin
        if (corner_count == 2'd0) begin
          corner_a <= vertex;
          corner_count <= 2'd1;
        end else if (corner_count == 2'd1) begin
          corner_b <= vertex;
          corner_count <= PHASE_TRI;
        end else begin
          predict_frame(corner_a, corner_b, vertex);
          corner_count <= 2'd0;
        end
      end
      if (tangent_valid && tangent_ready) begin
        if (frame_queue.size() == 0) begin
          report("unexpected transaction", tangent.tangent_x, '0);
        end else begin
          want = frame_queue.pop_front();
          if (tangent.tangent_x !== want.tangent_x)
            report("tangent_x", tangent.tangent_x, want.tangent_x);
          if (tangent.tangent_y !== want.tangent_y)
            report("tangent_y", tangent.tangent_y, want.tangent_y);
          if (tangent.tangent_z !== want.tangent_z)
            report("tangent_z", tangent.tangent_z, want.tangent_z);
          if (tangent.bitangent_x !== want.bitangent_x)
            report("bitangent_x", tangent.bitangent_x, want.bitangent_x);
          if (tangent.bitangent_y !== want.bitangent_y)
            report("bitangent_y", tangent.bitangent_y, want.bitangent_y);
          if (tangent.bitangent_z !== want.bitangent_z)
            report("bitangent_z", tangent.bitangent_z, want.bitangent_z);
          if (tangent.degenerate !== want.degenerate)
            report("degenerate", 32'(tangent.degenerate), 32'(want.degenerate));
          if (tangent.last_copy !== want.last_copy)
            report("last_copy", 32'(tangent.last_copy), 32'(want.last_copy));
        end
      end
    end
    frames_waiting = frame_queue.size();
  end
endmodule

>>> bench/tb_triangle_tangent_generator.sv
// Top of the tangent generator bench: clock, reset, vertex stimulus, output
// back-pressure and verdict. Depends on ttg_pkg, ttg_scoreboard and the block.
`timescale 1ns / 1ps
module tb_triangle_tangent_generator;
  import ttg_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      vertex_valid = 1'b0;
  logic      vertex_ready;
  in_item_t  vertex = '0;
  logic      tangent_valid;
  logic      tangent_ready = 1'b0;
  out_item_t tangent;
  int        error_count;
  int        frames_waiting;
  bit        idling_on = 1'b1;
  bit        hold_off = 1'b0;

  triangle_tangent_generator i_dut (
    .clk(clk), .rst(rst),
    .vertex_valid(vertex_valid), .vertex_ready(vertex_ready), .vertex(vertex),
    .tangent_valid(tangent_valid), .tangent_ready(tangent_ready), .tangent(tangent)
  );

  ttg_scoreboard i_checker (
    .clk(clk), .rst(rst),
    .vertex_valid(vertex_valid), .vertex_ready(vertex_ready), .vertex(vertex),
    .tangent_valid(tangent_valid), .tangent_ready(tangent_ready), .tangent(tangent),
    .error_count(error_count), .frames_waiting(frames_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t make_vertex(input int px, input int py, input int pz,
                                           input int tu, input int tv);
    in_item_t v;
    v.pos_x = px; v.pos_y = py; v.pos_z = pz; v.tex_u = tu; v.tex_v = tv;
    return v;
  endfunction

  function automatic int rand_coord(input int mode);
    case (mode)
      0:       return int'($urandom);
      1:       return int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Offer one vertex, optionally after an idle burst, and hold until taken
  task automatic offer_vertex(input in_item_t v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex <= v;
    do @(posedge clk); while (!vertex_ready);
  endtask

  task automatic offer_triangle(input in_item_t a, input in_item_t b, input in_item_t c);
    offer_vertex(a);
    offer_vertex(b);
    offer_vertex(c);
  endtask

  // Drop ready in random bursts, or for the long hold-off
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        tangent_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        tangent_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        tangent_ready <= 1'b1;
      end else begin
        tangent_ready <= 1'b1;
      end
    end
  end

  // Hold off the receiver long enough for the block to back up
  initial begin
    int cycles;
    @(negedge rst);
    repeat (2000) @(posedge clk);
    hold_off = 1'b1;
    for (cycles = 0; cycles < 1500; cycles++) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_triangle_tangent_generator: errors");
    $finish;
  end

  initial begin
    in_item_t a, b, c;
    int mode, kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: plain triangle, both determinant signs
    offer_triangle(make_vertex(0, 0, 0, 0, 0),
                   make_vertex(32'h10000, 0, 0, 32'h10000, 0),
                   make_vertex(0, 32'h10000, 0, 0, 32'h10000));
    offer_triangle(make_vertex(0, 0, 0, 0, 0),
                   make_vertex(32'h10000, 0, 0, 0, 32'h10000),
                   make_vertex(0, 32'h10000, 0, 32'h10000, 0));
    // Zero determinant: collinear texcoords
    offer_triangle(make_vertex(1, 2, 3, 5, 5),
                   make_vertex(7, 9, 11, 6, 6),
                   make_vertex(13, 4, 8, 7, 7));
    // Zero-length directions: all positions equal
    offer_triangle(make_vertex(9, 9, 9, 0, 0),
                   make_vertex(9, 9, 9, 32'h10000, 0),
                   make_vertex(9, 9, 9, 0, 32'h10000));
    // Field extremes
    offer_triangle(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000),
                   make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h7fff_ffff, 32'h8000_0000),
                   make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                               32'h8000_0000, 32'h7fff_ffff));
    offer_triangle(make_vertex(32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 0),
                   make_vertex(32'h8000_0000, 1, 32'h7fff_ffff, 0, 32'h7fff_ffff),
                   make_vertex(-1, -1, -1, 32'h8000_0000, 32'h8000_0000));
    // Tiny components flushed: nearly axis-aligned tangent
    offer_triangle(make_vertex(0, 0, 0, 0, 0),
                   make_vertex(32'h7fff_0000, 1, 0, 32'h10000, 0),
                   make_vertex(0, 0, 32'h10000, 0, 32'h10000));
    offer_triangle(make_vertex(-5, 3, -7, -1, -1),
                   make_vertex(-5, 3, -7, -1, -1),
                   make_vertex(4, 4, 4, 2, 3));

    // Random triangles: mostly well-formed, some small, some extreme or broken
    for (int t = 0; t < 29; t++) begin
      if (t == 24) idling_on = 1'b0;
      kind = $urandom_range(0, 9);
      mode = kind < 5 ? 0 : (kind < 8 ? 1 : 2);
      a = make_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_coord(mode), rand_coord(mode));
      b = make_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_coord(mode), rand_coord(mode));
      c = make_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_coord(mode), rand_coord(mode));
      // Collapse texcoords or positions now and then
      if (kind == 9) begin
        c.tex_u = b.tex_u;
        c.tex_v = b.tex_v;
      end else if (kind == 7) begin
        b.pos_x = a.pos_x; b.pos_y = a.pos_y; b.pos_z = a.pos_z;
        c.pos_x = a.pos_x; c.pos_y = a.pos_y; c.pos_z = a.pos_z;
      end
      offer_triangle(a, b, c);
    end
    vertex_valid <= 1'b0;

    // Drain, then let the block settle
    @(posedge clk);
    while (frames_waiting != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_triangle_tangent_generator: clean");
    end else begin
      $display("tb_triangle_tangent_generator: errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/ttg_pkg.sv
sv/ttg_ctrl.sv
sv/ttg_datapath.sv
sv/triangle_tangent_generator.sv
sv/ttg_checker.sv
bench/ttg_checker.sv
bench/tb_triangle_tangent_generator.sv
